/* design/cmps_pkg.sv */
// Shared types, constants and the pin table for the charlieplexed matrix scanner.
`timescale 1ns / 1ps

package cmps_pkg;

  localparam int unsigned MatrixCols = 44;
  localparam int unsigned MatrixRows = 11;
  localparam int unsigned PinCount   = 23;
  localparam int unsigned PairCount  = 22;

  localparam int unsigned ColW   = 5;
  localparam int unsigned PosXW  = 6;
  localparam int unsigned PosYW  = 4;
  localparam int unsigned PortAW = 16;
  localparam int unsigned PortBW = 24;
  localparam int unsigned PinW   = PortAW + PortBW;

  localparam logic KindWrite = 1'b0;
  localparam logic KindScan  = 1'b1;

  localparam logic [ColW-1:0] LastPair = ColW'(PairCount - 1);

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  typedef struct packed {
    logic pix_wr;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
    logic col_last;
  } sts_t;

  // Port A bits sit in [39:24], port B bits in [23:0].
  function automatic logic [PinW-1:0] pin_bits(logic [ColW-1:0] idx);
    logic [PinW-1:0] bits;
    case (idx)
      5'd0:    bits = {16'h0000, 24'h080000};
      5'd1:    bits = {16'h0000, 24'h100000};
      5'd2:    bits = {16'h0000, 24'h200000};
      5'd3:    bits = {16'h0000, 24'h800000};
      5'd4:    bits = {16'h0000, 24'h000002};
      5'd5:    bits = {16'h0000, 24'h000004};
      5'd6:    bits = {16'h0000, 24'h000010};
      5'd7:    bits = {16'h0000, 24'h000008};
      5'd8:    bits = {16'h0010, 24'h000000};
      5'd9:    bits = {16'h0000, 24'h000020};
      5'd10:   bits = {16'h0000, 24'h001000};
      5'd11:   bits = {16'h0000, 24'h002000};
      5'd12:   bits = {16'h0000, 24'h004000};
      5'd13:   bits = {16'h0000, 24'h008000};
      5'd14:   bits = {16'h0000, 24'h000100};
      5'd15:   bits = {16'h0000, 24'h000200};
      5'd16:   bits = {16'h0800, 24'h000000};
      5'd17:   bits = {16'h0400, 24'h000000};
      5'd18:   bits = {16'h1000, 24'h000000};
      5'd19:   bits = {16'h0000, 24'h000080};
      5'd20:   bits = {16'h0000, 24'h000001};
      5'd21:   bits = {16'h0000, 24'h040000};
      5'd22:   bits = {16'h8000, 24'h000000};
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

/* design/cmps_if.sv */
// Handshake interfaces for the request and result channels of the scanner.
`timescale 1ns / 1ps

interface cmps_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [cmps_pkg::PosXW-1:0]   pos_x;
  logic [cmps_pkg::PosYW-1:0]   pos_y;
  logic                         pixel_on;

  modport source (output valid, kind, pos_x, pos_y, pixel_on, input ready);
  modport sink (input valid, kind, pos_x, pos_y, pixel_on, output ready);
endinterface

interface cmps_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cmps_pkg::ColW-1:0]     column_pair;
  logic [cmps_pkg::PortAW-1:0]   out_port_a;
  logic [cmps_pkg::PortBW-1:0]   out_port_b;
  logic [cmps_pkg::PortAW-1:0]   dir_port_a;
  logic [cmps_pkg::PortBW-1:0]   dir_port_b;
  logic                          last_column;

  modport source (output valid, column_pair, out_port_a, out_port_b, dir_port_a,
                  dir_port_b, last_column, input ready);
  modport sink (input valid, column_pair, out_port_a, out_port_b, dir_port_a,
                dir_port_b, last_column, output ready);
endinterface

/* design/cmps_ctrl.sv */
// Controller state machine that sequences pixel writes and column scans.
`timescale 1ns / 1ps

module cmps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  input  logic          out_ready_i,
  input  cmps_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output cmps_pkg::cmd_t cmd_o
);

  cmps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmps_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.pix_wr  = 1'b0;
    cmd_o.load    = 1'b0;
    case (state_q)
      cmps_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == cmps_pkg::KindScan) begin
            state_d = cmps_pkg::StScan;
          end else begin
            cmd_o.pix_wr = 1'b1;
          end
        end
      end
      cmps_pkg::StScan: begin
        if (!sts_i.out_full || out_ready_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.col_last) begin
            state_d = cmps_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = cmps_pkg::StIdle;
      end
    endcase
  end

endmodule

/* design/cmps_dp.sv */
// Datapath with the frame store, the column counter and the result register.
`timescale 1ns / 1ps

module cmps_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmps_pkg::cmd_t                cmd_i,
  input  logic [cmps_pkg::PosXW-1:0]    pos_x_i,
  input  logic [cmps_pkg::PosYW-1:0]    pos_y_i,
  input  logic                          pixel_on_i,
  input  logic                          out_ready_i,
  output cmps_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  output logic [cmps_pkg::ColW-1:0]     column_pair_o,
  output logic [cmps_pkg::PortAW-1:0]   out_port_a_o,
  output logic [cmps_pkg::PortBW-1:0]   out_port_b_o,
  output logic [cmps_pkg::PortAW-1:0]   dir_port_a_o,
  output logic [cmps_pkg::PortBW-1:0]   dir_port_b_o,
  output logic                          last_column_o
);

  localparam int unsigned PinW = cmps_pkg::PinW;

  logic [cmps_pkg::MatrixCols-1:0] frame_q [cmps_pkg::MatrixRows];
  logic [cmps_pkg::ColW-1:0]       col_q, col_d;
  logic                            out_valid_q, out_valid_d;
  logic [cmps_pkg::ColW-1:0]       pair_q;
  logic [PinW-1:0]                 lvl_q, dir_q;
  logic                            last_q;

  logic [cmps_pkg::PairCount-1:0]  lit;
  logic [cmps_pkg::ColW-1:0]       anode;
  logic [PinW-1:0]                 lvl, dir;
  logic                            col_last;
  logic                            wr_hit;

  assign col_last = (col_q == cmps_pkg::LastPair);
  assign anode    = col_q + 5'd1;
  assign wr_hit   = cmd_i.pix_wr &&
                    (pos_x_i < cmps_pkg::PosXW'(cmps_pkg::MatrixCols)) &&
                    (pos_y_i < cmps_pkg::PosYW'(cmps_pkg::MatrixRows));

  always_comb begin
    for (int k = 0; k < int'(cmps_pkg::PairCount); k++) begin
      lit[k] = frame_q[k >> 1][{col_q, 1'(k)}];
    end
  end

  always_comb begin
    logic [cmps_pkg::ColW-1:0] pin;
    lvl = cmps_pkg::pin_bits(anode);
    dir = lvl;
    for (int k = 0; k < int'(cmps_pkg::PairCount); k++) begin
      pin = (5'(k) < anode) ? 5'(k) : 5'(k + 1);
      if (lit[k]) begin
        dir = dir | cmps_pkg::pin_bits(pin);
      end
    end
  end

  always_comb begin
    col_d       = col_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
      col_d       = col_last ? '0 : col_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < int'(cmps_pkg::MatrixRows); r++) begin
        frame_q[r] <= '0;
      end
    end else begin
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      if (wr_hit) begin
        frame_q[pos_y_i][pos_x_i] <= pixel_on_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pair_q <= col_q;
      lvl_q  <= lvl;
      dir_q  <= dir;
      last_q <= col_last;
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign sts_o.col_last = col_last;

  assign out_valid_o   = out_valid_q;
  assign column_pair_o = pair_q;
  assign out_port_a_o  = lvl_q[PinW-1:cmps_pkg::PortBW];
  assign out_port_b_o  = lvl_q[cmps_pkg::PortBW-1:0];
  assign dir_port_a_o  = dir_q[PinW-1:cmps_pkg::PortBW];
  assign dir_port_b_o  = dir_q[cmps_pkg::PortBW-1:0];
  assign last_column_o = last_q;

endmodule

/* design/charlieplex_matrix_scanner_top.sv */
// Top level of the charlieplexed LED matrix scanner.
`timescale 1ns / 1ps

// A pixel write word gives no result. A scan word gives 22 result words,
// one per column pair, at one per cycle while the sink keeps ready high;
// the scan occupies the block from the accepting cycle until the last column
// pair is sent, plus any output stall. The column counter steps one pair per
// cycle through the frame store while the sink keeps ready high.
// New words are refused during a scan. The frame store of 11 by 44 pixels is
// cleared at once by reset.
module charlieplex_matrix_scanner_top (
  input logic        clk_i,
  input logic        rst_ni,
  cmps_req_if.sink   req_i,
  cmps_rsp_if.source rsp_o
);

  cmps_pkg::cmd_t cmd;
  cmps_pkg::sts_t sts;

  cmps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_kind_i   (req_i.kind),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .in_ready_o  (req_i.ready),
    .cmd_o       (cmd)
  );

  cmps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .pos_x_i       (req_i.pos_x),
    .pos_y_i       (req_i.pos_y),
    .pixel_on_i    (req_i.pixel_on),
    .out_ready_i   (rsp_o.ready),
    .sts_o         (sts),
    .out_valid_o   (rsp_o.valid),
    .column_pair_o (rsp_o.column_pair),
    .out_port_a_o  (rsp_o.out_port_a),
    .out_port_b_o  (rsp_o.out_port_b),
    .dir_port_a_o  (rsp_o.dir_port_a),
    .dir_port_b_o  (rsp_o.dir_port_b),
    .last_column_o (rsp_o.last_column)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the charlieplexed LED matrix scanner top level.
`timescale 1ns / 1ps

module tb;
  import cmps_pkg::*;

  localparam int unsigned RunLimit   = 200000;
  localparam int unsigned DrainWait  = 2 * PairCount + 8;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned StallLen   = 300;

  typedef struct packed {
    logic [ColW-1:0]   pair;
    logic [PortAW-1:0] lvl_a;
    logic [PortBW-1:0] lvl_b;
    logic [PortAW-1:0] drv_a;
    logic [PortBW-1:0] drv_b;
    logic              last;
  } pattern_t;

  // Each entry is {port A, port B}.
  localparam logic [PinW-1:0] PinMap [PinCount] = '{
    40'h0000_080000, 40'h0000_100000, 40'h0000_200000, 40'h0000_800000,
    40'h0000_000002, 40'h0000_000004, 40'h0000_000010, 40'h0000_000008,
    40'h0010_000000, 40'h0000_000020, 40'h0000_001000, 40'h0000_002000,
    40'h0000_004000, 40'h0000_008000, 40'h0000_000100, 40'h0000_000200,
    40'h0800_000000, 40'h0400_000000, 40'h1000_000000, 40'h0000_000080,
    40'h0000_000001, 40'h0000_040000, 40'h8000_000000
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  cmps_req_if req_bus ();
  cmps_rsp_if rsp_bus ();

  charlieplex_matrix_scanner_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  logic [MatrixCols-1:0] frame_model [MatrixRows] = '{default: '0};
  pattern_t              pending_patterns [$];
  int unsigned           failures      = 0;
  int unsigned           src_idle_pct  = 6;
  int unsigned           sink_idle_pct = 6;
  int unsigned           hold_left     = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic pattern_t column_pattern(int unsigned pair);
    int unsigned     anode;
    int unsigned     pin;
    int unsigned     k;
    logic [PinW-1:0] lvl;
    logic [PinW-1:0] drv;
    pattern_t        p;
    anode = pair + 1;
    lvl   = PinMap[anode];
    drv   = lvl;
    for (k = 0; k < PairCount; k++) begin
      pin = (k < anode) ? k : k + 1;
      if (frame_model[k >> 1][2 * pair + (k & 1)]) drv |= PinMap[pin];
    end
    p.pair  = ColW'(pair);
    p.lvl_a = lvl[PinW-1:PortBW];
    p.lvl_b = lvl[PortBW-1:0];
    p.drv_a = drv[PinW-1:PortBW];
    p.drv_b = drv[PortBW-1:0];
    p.last  = (pair == PairCount - 1);
    return p;
  endfunction

  task automatic note_failure(string what, pattern_t want, pattern_t got);
    failures++;
    if (failures <= MaxReports) begin
      $display("%0t %s: expected pair %0d out %h/%h dir %h/%h last %b",
               $realtime, what, want.pair, want.lvl_a, want.lvl_b,
               want.drv_a, want.drv_b, want.last);
      $display("%0t %s: actual   pair %0d out %h/%h dir %h/%h last %b",
               $realtime, what, got.pair, got.lvl_a, got.lvl_b,
               got.drv_a, got.drv_b, got.last);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    pattern_t    got;
    pattern_t    want;
    int unsigned c;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        if (req_bus.kind == KindWrite) begin
          if (req_bus.pos_x < MatrixCols && req_bus.pos_y < MatrixRows)
            frame_model[req_bus.pos_y][req_bus.pos_x] = req_bus.pixel_on;
        end else begin
          for (c = 0; c < PairCount; c++) pending_patterns.push_back(column_pattern(c));
        end
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = {rsp_bus.column_pair, rsp_bus.out_port_a, rsp_bus.out_port_b,
               rsp_bus.dir_port_a, rsp_bus.dir_port_b, rsp_bus.last_column};
        if (pending_patterns.size() == 0) begin
          note_failure("unexpected word", '0, got);
        end else begin
          want = pending_patterns.pop_front();
          if (got.pair !== want.pair || got.lvl_a !== want.lvl_a ||
              got.lvl_b !== want.lvl_b || got.drv_a !== want.drv_a ||
              got.drv_b !== want.drv_b || got.last !== want.last)
            note_failure("mismatch", want, got);
        end
      end
    end
  end

  initial rsp_bus.ready = 1'b0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_word(logic kind, logic [PosXW-1:0] x, logic [PosYW-1:0] y,
                           logic on);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.kind     <= kind;
    req_bus.pos_x    <= x;
    req_bus.pos_y    <= y;
    req_bus.pixel_on <= on;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  task automatic test_blank_scan();
    send_word(KindScan, '0, '0, 1'b0);
    send_word(KindScan, '1, '1, 1'b1);
  endtask

  task automatic test_directed_pixels();
    send_word(KindWrite, 6'd0, 4'd0, 1'b1);
    send_word(KindWrite, 6'd43, 4'd10, 1'b1);
    send_word(KindWrite, 6'd43, 4'd0, 1'b1);
    send_word(KindWrite, 6'd0, 4'd10, 1'b1);
    send_word(KindWrite, 6'd1, 4'd0, 1'b1);
    send_word(KindWrite, 6'd42, 4'd10, 1'b1);
    send_word(KindWrite, 6'd21, 4'd5, 1'b1);
    send_word(KindScan, 6'd0, 4'd0, 1'b0);
    send_word(KindWrite, 6'd44, 4'd0, 1'b1);
    send_word(KindWrite, 6'd0, 4'd11, 1'b1);
    send_word(KindWrite, 6'd63, 4'd15, 1'b1);
    send_word(KindWrite, 6'd63, 4'd3, 1'b1);
    send_word(KindWrite, 6'd7, 4'd15, 1'b1);
    send_word(KindScan, 6'd0, 4'd0, 1'b0);
    send_word(KindWrite, 6'd0, 4'd0, 1'b0);
    send_word(KindWrite, 6'd43, 4'd10, 1'b0);
    send_word(KindWrite, 6'd21, 4'd5, 1'b0);
    send_word(KindWrite, 6'd21, 4'd5, 1'b0);
    send_word(KindScan, 6'd0, 4'd0, 1'b0);
  endtask

  task automatic run_random(int unsigned count, int unsigned lit_pct);
    int unsigned      done;
    logic             kind;
    logic [PosXW-1:0] x;
    logic [PosYW-1:0] y;
    logic             on;
    done = 0;
    while (done < count) begin
      kind = ($urandom_range(99) < 12) ? KindScan : KindWrite;
      if ($urandom_range(99) < 8) begin
        x = PosXW'($urandom_range(63));
        y = PosYW'($urandom_range(15));
      end else begin
        x = PosXW'($urandom_range(MatrixCols - 1));
        y = PosYW'($urandom_range(MatrixRows - 1));
      end
      on = ($urandom_range(99) < lit_pct);
      send_word(kind, x, y, on);
      if (kind == KindScan || (x < MatrixCols && y < MatrixRows)) done++;
    end
  endtask

  task automatic test_random_mix();
    run_random(150, 50);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(100, 50);
    src_idle_pct  = 6;
    sink_idle_pct = 6;
    run_random(150, 85);
  endtask

  task automatic test_output_stall();
    int unsigned i;
    req_bus.valid <= 1'b0;
    @(negedge clk_i);
    hold_left = StallLen;
    @(posedge clk_i);
    for (i = 0; i < 8; i++) begin
      send_word((i % 2 == 0) ? KindScan : KindWrite,
                PosXW'($urandom_range(MatrixCols - 1)),
                PosYW'($urandom_range(MatrixRows - 1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.kind     = KindWrite;
    req_bus.pos_x    = '0;
    req_bus.pos_y    = '0;
    req_bus.pixel_on = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_blank_scan();
    test_directed_pixels();
    test_random_mix();
    test_output_stall();
    req_bus.valid <= 1'b0;
    while (pending_patterns.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < RunLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
design/cmps_pkg.sv
design/cmps_if.sv
design/cmps_ctrl.sv
design/cmps_dp.sv
design/charlieplex_matrix_scanner_top.sv
tb/tb.sv
